// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the floor span builder; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define FSB_ASSERT(label, ck, rst_n, prop, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);
`define FSB_ASSERT_NEVER(label, ck, rst_n, expr, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define FSB_ASSERT(label, ck, rst_n, prop, msg)
`define FSB_ASSERT_NEVER(label, ck, rst_n, expr, msg)
`endif

`endif

// File: design/fsb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsb_pkg
// Shared types, constants and state encodings of the floor span builder.
// ----------------------------------------------------------------------------
package fsb_pkg;

	localparam int ROWS_DEF        = 64;
	localparam int COLUMN_BITS_DEF = 10;
	localparam int ROW_CW          = 7;   // row counters, 0..64
	localparam int COL_MAX_W       = 12;
	localparam int DVD_W           = 34;  // signed dividend
	localparam int DVS_W           = 18;  // signed divisor
	localparam int CFG_IDX_W       = 3;

	localparam logic [5:0] HORIZON_RESET = 6'd32;
	localparam logic [9:0] SD_RESET      = 10'd160;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HEIGHT_COS      = 3'd0,
		CFG_HEIGHT_SIN      = 3'd1,
		CFG_OFFSET_X        = 3'd2,
		CFG_OFFSET_Y        = 3'd3,
		CFG_HORIZON_ROW     = 3'd4,
		CFG_SCREEN_DISTANCE = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [31:0] height_cos;
		logic [31:0] height_sin;
		logic [21:0] offset_x;
		logic [21:0] offset_y;
		logic [5:0]  horizon_row;
		logic [9:0]  screen_distance;
	} cfg_t;

	typedef struct packed {
		logic [5:0]           row;
		logic [COL_MAX_W-1:0] start;
	} span_req_t;

	typedef struct packed {
		logic [31:0] step_x;
		logic [31:0] step_y;
		logic [31:0] start_x;
		logic [31:0] start_y;
	} span_res_t;

	typedef enum logic [2:0] {
		SC_IDLE, SC_PREP, SC_DSTART, SC_DWAIT, SC_MULX, SC_MULY, SC_FIN
	} sc_state_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_TOP, ST_BOT, ST_UPD, ST_FILLA, ST_FILLB, ST_LAST,
		ST_FLUSH, ST_RD, ST_GO, ST_WAIT, ST_PUSH, ST_END
	} fsb_state_t;

endpackage

// File: design/fsb_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsb_div
// Shared signed divider, restoring, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module fsb_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [fsb_pkg::DVD_W-1:0]  dividend,
	input  logic signed [fsb_pkg::DVS_W-1:0]  divisor,
	output logic                              done,
	output logic        [31:0]                quotient
);
	localparam int MW   = fsb_pkg::DVD_W - 1;
	localparam int SW   = fsb_pkg::DVS_W - 1;
	localparam int CW   = $clog2(MW);
	localparam logic [CW-1:0] LAST_CNT = CW'(MW - 1);

	logic          busy_q, done_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [MW-1:0] dq_q;
	logic [SW-1:0] rem_q, dvs_q;
	logic [fsb_pkg::DVD_W-1:0] dvd_abs;
	logic [fsb_pkg::DVS_W-1:0] dvs_abs;
	logic [SW:0]   trial, diff;
	logic          ge;
	logic [MW-1:0] q_signed;

	always_comb begin
		dvd_abs  = dividend[fsb_pkg::DVD_W-1] ? -dividend : dividend;
		dvs_abs  = divisor[fsb_pkg::DVS_W-1] ? -divisor : divisor;
		trial    = {rem_q, dq_q[MW-1]};
		diff     = trial - {1'b0, dvs_q};
		ge       = trial >= {1'b0, dvs_q};
		q_signed = neg_q ? -dq_q : dq_q;
	end

	assign done     = done_q;
	assign quotient = q_signed[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_CNT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[fsb_pkg::DVD_W-1] ^ divisor[fsb_pkg::DVS_W-1];
			dq_q  <= dvd_abs[MW-1:0];
			dvs_q <= dvs_abs[SW-1:0];
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[SW-1:0] : trial[SW-1:0];
			dq_q  <= {dq_q[MW-2:0], ge};
		end
	end

endmodule

// File: design/fsb_span_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsb_span_calc
// Per-span texture math: four divisions on the shared divider, then the
// start coordinates through one shared multiplier.
// ----------------------------------------------------------------------------
module fsb_span_calc (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  fsb_pkg::span_req_t req,
	input  fsb_pkg::cfg_t      cfg,
	output logic               done,
	output fsb_pkg::span_res_t res
);
	localparam int DW = fsb_pkg::DVD_W;
	localparam int VW = fsb_pkg::DVS_W;
	localparam int CM = fsb_pkg::COL_MAX_W;

	fsb_pkg::sc_state_t st_q, st_nxt;
	logic [1:0]           k_q;
	logic signed [6:0]    den_q;
	logic signed [VW-1:0] dsd_q;
	logic [CM-1:0]        start_q;
	logic [31:0]          q_q [4];
	logic [31:0]          prod_q, fx_q, fy_q;

	logic [9:0]           sd_eff;
	logic signed [DW-1:0] hc, hs, dvd;
	logic signed [VW-1:0] dvs;
	logic                 div_start, div_done;
	logic [31:0]          div_quo, mul_a;
	logic [31+CM:0]       mul_full;

	always_comb begin
		sd_eff = (cfg.screen_distance == '0) ? 10'd1 : cfg.screen_distance;
		hc     = DW'($signed(cfg.height_cos));
		hs     = DW'($signed(cfg.height_sin));
		case (k_q)
			2'd0: begin dvd = -hc;     dvs = dsd_q;       end
			2'd1: begin dvd = -hs;     dvs = dsd_q;       end
			2'd2: begin dvd = hc - hs; dvs = VW'(den_q);  end
			2'd3: begin dvd = hs + hc; dvs = VW'(den_q);  end
			default: begin dvd = '0;   dvs = VW'(den_q);  end
		endcase
		mul_a    = (st_q == fsb_pkg::SC_MULX) ? q_q[0] : q_q[1];
		mul_full = {{CM{1'b0}}, mul_a} * {32'b0, start_q};
	end

	fsb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		st_nxt = st_q;
		case (st_q)
			fsb_pkg::SC_IDLE:   if (go) st_nxt = fsb_pkg::SC_PREP;
			fsb_pkg::SC_PREP:   st_nxt = fsb_pkg::SC_DSTART;
			fsb_pkg::SC_DSTART: st_nxt = fsb_pkg::SC_DWAIT;
			fsb_pkg::SC_DWAIT:  if (div_done)
				st_nxt = (k_q == 2'd3) ? fsb_pkg::SC_MULX : fsb_pkg::SC_DSTART;
			fsb_pkg::SC_MULX:   st_nxt = fsb_pkg::SC_MULY;
			fsb_pkg::SC_MULY:   st_nxt = fsb_pkg::SC_FIN;
			fsb_pkg::SC_FIN:    st_nxt = fsb_pkg::SC_IDLE;
			default:            st_nxt = fsb_pkg::SC_IDLE;
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		done      = 1'b0;
		case (st_q)
			fsb_pkg::SC_DSTART: div_start = 1'b1;
			fsb_pkg::SC_FIN:    done      = 1'b1;
			default: ;
		endcase
		res.step_x  = q_q[0];
		res.step_y  = q_q[1];
		res.start_x = fx_q;
		res.start_y = fy_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= fsb_pkg::SC_IDLE;
			k_q  <= '0;
		end else begin
			st_q <= st_nxt;
			if (st_q == fsb_pkg::SC_PREP)
				k_q <= '0;
			else if (st_q == fsb_pkg::SC_DWAIT && div_done)
				k_q <= k_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			fsb_pkg::SC_IDLE: if (go) begin
				den_q   <= 7'({1'b0, req.row}) - 7'({1'b0, cfg.horizon_row});
				start_q <= req.start;
			end
			fsb_pkg::SC_PREP:
				dsd_q <= VW'(den_q) * $signed(VW'({1'b0, sd_eff}));
			fsb_pkg::SC_DWAIT: if (div_done) q_q[k_q] <= div_quo;
			fsb_pkg::SC_MULX: prod_q <= mul_full[31:0];
			fsb_pkg::SC_MULY: begin
				fx_q   <= prod_q + q_q[2] - 32'(cfg.offset_x);
				prod_q <= mul_full[31:0];
			end
			fsb_pkg::SC_FIN: fy_q <= prod_q + q_q[3] + 32'(cfg.offset_y);
			default: ;
		endcase
	end

endmodule

// File: design/floor_span_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// floor_span_builder
// Turns per-column visible floor row ranges into textured horizontal spans.
// ----------------------------------------------------------------------------
// Usage: one item transaction per screen column, left to right, on
// item_valid/item_ready. Each column closes spans for rows that left the open
// range (rows above the new top ascending, then rows below the new bottom
// descending); a column with last_column set then flushes all open rows.
// Each span leaves on span_valid/span_ready; run_end marks the last span of
// a column. Registers are written on cfg_valid/cfg_ready; the user must
// write them only while idle, the block does not enforce it. A row on the
// horizon row yields no span. A column writes a row start per newly opened
// row, a last column adds a flush; each span runs the shared 33-step divider
// four times, then multiply and add steps. item_ready is high only idle.
// A span is held back one slot so run_end can be set; a stalled receiver
// holds the block in its push step until the output register frees up.
// Reset: open range empty, registers at defaults (horizon row 32, screen
// distance 160); the row start memory is not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module floor_span_builder #(
	parameter int ROWS        = fsb_pkg::ROWS_DEF,
	parameter int COLUMN_BITS = fsb_pkg::COLUMN_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic [COLUMN_BITS-1:0]            column,
	input  logic [6:0]                        top_row,
	input  logic [6:0]                        bottom_row,
	input  logic                              last_column,
	output logic                              span_valid,
	input  logic                              span_ready,
	output logic [5:0]                        span_row,
	output logic [COLUMN_BITS-1:0]            span_start,
	output logic [COLUMN_BITS:0]              span_end,
	output logic signed [31:0]                step_x,
	output logic signed [31:0]                step_y,
	output logic signed [31:0]                start_x,
	output logic signed [31:0]                start_y,
	output logic                              run_end,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fsb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                       cfg_data
);
	localparam int RW   = fsb_pkg::ROW_CW;
	localparam int RA_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [RW-1:0] ROWS_C = RW'(ROWS);

	fsb_pkg::cfg_t      cfg_q;
	fsb_pkg::fsb_state_t st_q, st_nxt, ret_q;

	logic [COLUMN_BITS-1:0] col_q, rd_q;
	logic [COLUMN_BITS:0]   end_q;
	logic                   last_q;
	logic [RW-1:0] nt_q, nb_q, t_q, b_q, open_top_q, open_bot_q, y_q, row_q;
	logic [RW-1:0] fill_hi_q, fillb_lo_q, fillb_hi_q, nt_in, nb_in;
	logic [COLUMN_BITS-1:0] mem [ROWS];

	logic                   pend_full_q;
	logic [5:0]             pend_row_q;
	logic [COLUMN_BITS-1:0] pend_start_q;
	logic [COLUMN_BITS:0]   pend_end_q;
	fsb_pkg::span_res_t     pend_res_q;

	logic                   out_valid_q, out_last_q;
	logic [5:0]             out_row_q;
	logic [COLUMN_BITS-1:0] out_start_q;
	logic [COLUMN_BITS:0]   out_end_q;
	fsb_pkg::span_res_t     out_res_q;

	logic top_go, bot_go, fill_a_go, fill_b_go, flush_go, horizon_hit, out_free;
	logic mem_we, mem_re, calc_go, calc_done, pend_load, pend_to_out;
	fsb_pkg::span_req_t calc_req;
	fsb_pkg::span_res_t calc_res;

	always_comb begin
		nt_in       = (top_row > ROWS_C) ? ROWS_C : top_row;
		nb_in       = (bottom_row > ROWS_C) ? ROWS_C : bottom_row;
		top_go      = (t_q < nt_q) && (t_q < b_q);
		bot_go      = (b_q > nb_q) && (t_q < b_q);
		fill_a_go   = y_q < fill_hi_q;
		fill_b_go   = y_q < fillb_hi_q;
		flush_go    = y_q < open_bot_q;
		horizon_hit = row_q[5:0] == cfg_q.horizon_row;
		out_free    = !out_valid_q || span_ready;
		calc_req.row   = row_q[5:0];
		calc_req.start = fsb_pkg::COL_MAX_W'(rd_q);
	end

	fsb_span_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (calc_go),
		.req    (calc_req),
		.cfg    (cfg_q),
		.done   (calc_done),
		.res    (calc_res)
	);

	always_comb begin
		st_nxt = st_q;
		case (st_q)
			fsb_pkg::ST_IDLE:  if (item_valid) st_nxt = fsb_pkg::ST_TOP;
			fsb_pkg::ST_TOP:   st_nxt = top_go ? fsb_pkg::ST_RD : fsb_pkg::ST_BOT;
			fsb_pkg::ST_BOT:   st_nxt = bot_go ? fsb_pkg::ST_RD : fsb_pkg::ST_UPD;
			fsb_pkg::ST_UPD:   st_nxt = fsb_pkg::ST_FILLA;
			fsb_pkg::ST_FILLA: st_nxt = fill_a_go ? fsb_pkg::ST_FILLA : fsb_pkg::ST_FILLB;
			fsb_pkg::ST_FILLB: st_nxt = fill_b_go ? fsb_pkg::ST_FILLB : fsb_pkg::ST_LAST;
			fsb_pkg::ST_LAST:  st_nxt = last_q ? fsb_pkg::ST_FLUSH : fsb_pkg::ST_END;
			fsb_pkg::ST_FLUSH: st_nxt = flush_go ? fsb_pkg::ST_RD : fsb_pkg::ST_END;
			fsb_pkg::ST_RD:    st_nxt = horizon_hit ? ret_q : fsb_pkg::ST_GO;
			fsb_pkg::ST_GO:    st_nxt = fsb_pkg::ST_WAIT;
			fsb_pkg::ST_WAIT:  if (calc_done) st_nxt = fsb_pkg::ST_PUSH;
			fsb_pkg::ST_PUSH:  if (!pend_full_q || out_free) st_nxt = ret_q;
			fsb_pkg::ST_END:   if (!pend_full_q || out_free) st_nxt = fsb_pkg::ST_IDLE;
			default:           st_nxt = fsb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready  = 1'b0;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		calc_go     = 1'b0;
		pend_load   = 1'b0;
		pend_to_out = 1'b0;
		case (st_q)
			fsb_pkg::ST_IDLE:  item_ready = 1'b1;
			fsb_pkg::ST_FILLA: mem_we = fill_a_go;
			fsb_pkg::ST_FILLB: mem_we = fill_b_go;
			fsb_pkg::ST_RD:    mem_re = !horizon_hit;
			fsb_pkg::ST_GO:    calc_go = 1'b1;
			fsb_pkg::ST_PUSH: begin
				pend_load   = !pend_full_q || out_free;
				pend_to_out = pend_full_q && out_free;
			end
			fsb_pkg::ST_END:   pend_to_out = pend_full_q && out_free;
			default: ;
		endcase
	end

	assign cfg_ready  = 1'b1;
	assign span_valid = out_valid_q;
	assign span_row   = out_row_q;
	assign span_start = out_start_q;
	assign span_end   = out_end_q;
	assign step_x     = $signed(out_res_q.step_x);
	assign step_y     = $signed(out_res_q.step_y);
	assign start_x    = $signed(out_res_q.start_x);
	assign start_y    = $signed(out_res_q.start_y);
	assign run_end    = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.height_cos      <= '0;
			cfg_q.height_sin      <= '0;
			cfg_q.offset_x        <= '0;
			cfg_q.offset_y        <= '0;
			cfg_q.horizon_row     <= fsb_pkg::HORIZON_RESET;
			cfg_q.screen_distance <= fsb_pkg::SD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (fsb_pkg::cfg_idx_t'(cfg_index))
				fsb_pkg::CFG_HEIGHT_COS:      cfg_q.height_cos      <= cfg_data;
				fsb_pkg::CFG_HEIGHT_SIN:      cfg_q.height_sin      <= cfg_data;
				fsb_pkg::CFG_OFFSET_X:        cfg_q.offset_x        <= cfg_data[21:0];
				fsb_pkg::CFG_OFFSET_Y:        cfg_q.offset_y        <= cfg_data[21:0];
				fsb_pkg::CFG_HORIZON_ROW:     cfg_q.horizon_row     <= cfg_data[5:0];
				fsb_pkg::CFG_SCREEN_DISTANCE: cfg_q.screen_distance <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= fsb_pkg::ST_IDLE;
			ret_q       <= fsb_pkg::ST_IDLE;
			open_top_q  <= '0;
			open_bot_q  <= '0;
			t_q         <= '0;
			b_q         <= '0;
			nt_q        <= '0;
			nb_q        <= '0;
			y_q         <= '0;
			row_q       <= '0;
			fill_hi_q   <= '0;
			fillb_lo_q  <= '0;
			fillb_hi_q  <= '0;
			last_q      <= 1'b0;
			pend_full_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_nxt;
			case (st_q)
				fsb_pkg::ST_IDLE: if (item_valid) begin
					nt_q   <= nt_in;
					nb_q   <= nb_in;
					last_q <= last_column;
					t_q    <= open_top_q;
					b_q    <= open_bot_q;
				end
				fsb_pkg::ST_TOP: if (top_go) begin
					row_q <= t_q;
					t_q   <= t_q + 1'b1;
					ret_q <= fsb_pkg::ST_TOP;
				end
				fsb_pkg::ST_BOT: if (bot_go) begin
					row_q <= b_q - 1'b1;
					b_q   <= b_q - 1'b1;
					ret_q <= fsb_pkg::ST_BOT;
				end
				fsb_pkg::ST_UPD: begin
					if (nt_q < nb_q) begin
						open_top_q <= nt_q;
						open_bot_q <= nb_q;
						y_q        <= nt_q;
						if (t_q < b_q) begin
							fill_hi_q  <= t_q;
							fillb_lo_q <= b_q;
						end else begin
							fill_hi_q  <= nb_q;
							fillb_lo_q <= nb_q;
						end
						fillb_hi_q <= nb_q;
					end else begin
						open_top_q <= '0;
						open_bot_q <= '0;
						y_q        <= '0;
						fill_hi_q  <= '0;
						fillb_lo_q <= '0;
						fillb_hi_q <= '0;
					end
				end
				fsb_pkg::ST_FILLA: y_q <= fill_a_go ? y_q + 1'b1 : fillb_lo_q;
				fsb_pkg::ST_FILLB: if (fill_b_go) y_q <= y_q + 1'b1;
				fsb_pkg::ST_LAST:  y_q <= open_top_q;
				fsb_pkg::ST_FLUSH: begin
					if (flush_go) begin
						row_q <= y_q;
						y_q   <= y_q + 1'b1;
						ret_q <= fsb_pkg::ST_FLUSH;
					end else begin
						open_top_q <= '0;
						open_bot_q <= '0;
					end
				end
				default: ;
			endcase

			if (pend_load)
				pend_full_q <= 1'b1;
			else if (pend_to_out)
				pend_full_q <= 1'b0;

			if (pend_to_out)
				out_valid_q <= 1'b1;
			else if (span_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == fsb_pkg::ST_IDLE && item_valid)
			col_q <= column;
		if (st_q == fsb_pkg::ST_TOP || st_q == fsb_pkg::ST_BOT)
			end_q <= {1'b0, col_q};
		else if (st_q == fsb_pkg::ST_FLUSH)
			end_q <= {1'b0, col_q} + 1'b1;
		if (mem_we)
			mem[y_q[RA_W-1:0]] <= col_q;
		if (mem_re)
			rd_q <= mem[row_q[RA_W-1:0]];
		if (pend_to_out) begin
			out_row_q   <= pend_row_q;
			out_start_q <= pend_start_q;
			out_end_q   <= pend_end_q;
			out_res_q   <= pend_res_q;
			out_last_q  <= (st_q == fsb_pkg::ST_END);
		end
		if (pend_load) begin
			pend_row_q   <= row_q[5:0];
			pend_start_q <= rd_q;
			pend_end_q   <= end_q;
			pend_res_q   <= calc_res;
		end
	end

	`FSB_ASSERT(a_open_order, clk, arst_n, (open_top_q <= open_bot_q) && (open_bot_q <= ROWS_C), "open row range out of order")
	`FSB_ASSERT(a_idle_drained, clk, arst_n, (st_q == fsb_pkg::ST_IDLE) |-> !pend_full_q, "span held back while idle")
	`FSB_ASSERT(a_done_waited, clk, arst_n, calc_done |-> (st_q == fsb_pkg::ST_WAIT), "span math finished unexpectedly")
	`FSB_ASSERT_NEVER(a_fill_range, clk, arst_n, mem_we && (y_q >= ROWS_C), "row start write beyond rows")

endmodule
